### rtl/tcla_pkg.sv
`timescale 1ns / 1ps

package tcla_pkg;

    // Line storage geometry.
    localparam int ADDR_W = 6;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DEPTH  = 1 << ADDR_W;

    // Longest line kept, and the value of the line length register after reset.
    localparam logic [CNT_W-1:0] LINE_CHARS_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CPL_RESET      = CNT_W'(DEPTH);

    // Line ending characters.
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_write;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        out_char;
        logic [ADDR_W-1:0] column;
        logic              empty_line;
        logic              last_of_line;
    } out_item_t;

endpackage

### rtl/tcla_ram.sv
`timescale 1ns / 1ps

module tcla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/text_console_line_assembler.sv
`timescale 1ns / 1ps
// Ordinary bytes and swallowed LFs are accepted whenever no line is being emitted.
// A CR or LF commit reads each character from the line RAM and registers it as a result;
// each read waits for a free output register, bound by the interlocked line RAM read port.
// A committed line of n characters gives n results, or one empty-line result if n is 0.
// Reset is asynchronous and active low; it empties the line and sets the length to 64.
// The line RAM is not cleared: only entries already written are ever emitted.

module text_console_line_assembler
    import tcla_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  in_item_t        in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output out_item_t       out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              cr_reg, cr_next;
    logic [CNT_W-1:0]  cpl_reg, cpl_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              in_fire;
    logic              out_free;
    logic              commit;
    logic              is_last;
    logic [CNT_W-1:0]  limit;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;

    // Line characters live in the RAM, written at the fill position.
    tcla_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (in_data.text_byte),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign limit    = (cpl_reg > LINE_CHARS_MAX) ? LINE_CHARS_MAX : cpl_reg;
    assign is_last  = (len_reg == '0) || ((CNT_W'(idx_reg) + CNT_W'(1)) == len_reg);

    // Length register writes, input decode, line filling, and the read-then-emit sequence of a commit.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cr_next        = cr_reg;
        cpl_next       = cpl_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        commit         = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            cpl_next = cfg_data;
        end

        if (in_fire)
        begin
            cr_next = 1'b0;
            if (in_data.text_byte == CH_CR)
            begin
                cr_next = !in_data.end_of_write;
                commit  = 1'b1;
            end
            else if (in_data.text_byte == CH_LF)
            begin
                commit = !cr_reg;
            end
            else if (fill_reg < limit)
            begin
                ram_we    = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
            end
        end

        if (commit)
        begin
            len_next   = fill_reg;
            fill_next  = '0;
            idx_next   = '0;
            state_next = ST_STREAM;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // A read is issued only once the output register will be free for its data.
        if (state_reg == ST_STREAM)
        begin
            if (pend_reg)
            begin
                pend_next                  = 1'b0;
                out_valid_next             = 1'b1;
                out_item_next.out_char     = (len_reg == '0) ? 8'd0 : ram_rdata;
                out_item_next.column       = idx_reg;
                out_item_next.empty_line   = (len_reg == '0);
                out_item_next.last_of_line = is_last;
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            else if (out_free)
            begin
                ram_re    = 1'b1;
                pend_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cr_reg        <= 1'b0;
            cpl_reg       <= CPL_RESET;
            len_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cr_reg        <= cr_next;
            cpl_reg       <= cpl_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // A pending read always finds the output register empty.
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |-> !out_valid_reg)
        else $error("line RAM data returned while output register full");

    // An empty-line result is always the final result of its line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.empty_line |-> out_data.last_of_line)
        else $error("empty-line result not marked last");

    // A CR transfer always starts the emission of a line.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_data.text_byte == CH_CR) |=> state_reg == ST_STREAM)
        else $error("CR did not commit the line");

    // While a line is emitted, the next line has been restarted empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STREAM |-> fill_reg == '0)
        else $error("line not restarted at commit");

endmodule

### tb/text_console_line_assembler_test.sv
`timescale 1ns / 1ps

module text_console_line_assembler_test;
    import tcla_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 380;
    localparam int PHASE_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // Predicts the committed lines from the accepted bytes and checks each result transfer
    // against the oldest character still awaited.
    class committed_line_board;
        logic [7:0]       line_chars [DEPTH];
        int unsigned      held;
        bit               cr_seen;
        logic [CNT_W-1:0] line_length;
        out_item_t        awaited_chars [$];
        int unsigned      mismatches;

        function new();
            held        = 0;
            cr_seen     = 1'b0;
            line_length = CPL_RESET;
            mismatches  = 0;
        endfunction

        function void set_length(logic [CNT_W-1:0] value);
            line_length = value;
        endfunction

        function int unsigned pending();
            return awaited_chars.size();
        endfunction

        // A commit gives one result per held character, or a single empty-line marker.
        function void commit_line();
            out_item_t e;
            int unsigned k;
            if (held == 0)
            begin
                e.out_char     = 8'd0;
                e.column       = '0;
                e.empty_line   = 1'b1;
                e.last_of_line = 1'b1;
                awaited_chars.push_back(e);
            end
            else
            begin
                for (k = 0; k < held; k++)
                begin
                    e.out_char     = line_chars[k];
                    e.column       = ADDR_W'(k);
                    e.empty_line   = 1'b0;
                    e.last_of_line = (k + 1 == held);
                    awaited_chars.push_back(e);
                end
            end
            held = 0;
        endfunction

        function void take_byte(in_item_t it);
            bit after_cr;
            int unsigned limit;
            after_cr = cr_seen;
            cr_seen  = 1'b0;
            limit    = 32'((line_length > LINE_CHARS_MAX) ? LINE_CHARS_MAX : line_length);
            if (it.text_byte == CH_CR)
            begin
                // A CR that ends its write call cannot pair with the next LF.
                cr_seen = !it.end_of_write;
                commit_line();
            end
            else if (it.text_byte == CH_LF)
            begin
                if (!after_cr)
                    commit_line();
            end
            else if (held < limit)
            begin
                line_chars[held] = it.text_byte;
                held++;
            end
        endfunction

        function void note_mismatch(string what, out_item_t e, out_item_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: %s: expected char %02h col %0d empty %0b last %0b",
                         $time, what, e.out_char, e.column, e.empty_line, e.last_of_line);
                $display("    got char %02h col %0d empty %0b last %0b",
                         got.out_char, got.column, got.empty_line, got.last_of_line);
            end
        endfunction

        function void compare_result(out_item_t got);
            out_item_t e;
            if (awaited_chars.size() == 0)
            begin
                e = '0;
                note_mismatch("result with nothing awaited", e, got);
            end
            else
            begin
                e = awaited_chars.pop_front();
                if (got.out_char !== e.out_char || got.column !== e.column ||
                    got.empty_line !== e.empty_line || got.last_of_line !== e.last_of_line)
                    note_mismatch("result mismatch", e, got);
            end
        endfunction

        function void report_leftover();
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %0d expected results never arrived",
                         $time, awaited_chars.size());
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    committed_line_board board;
    logic [CNT_W-1:0]    cur_length;
    int unsigned         sent_count;
    bit                  src_calm;
    bit                  snk_calm;
    bit                  hold_request;

    text_console_line_assembler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Any byte that is not a line ending.
    function automatic logic [7:0] text_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Line lengths cluster around short lines and the current limit, with a few long ones.
    function automatic int unsigned pick_line_len(logic [CNT_W-1:0] length_reg);
        int unsigned r;
        int unsigned lim;
        r   = $urandom_range(0, 99);
        lim = 32'((length_reg > LINE_CHARS_MAX) ? LINE_CHARS_MAX : length_reg);
        if (r < 50)
            return $urandom_range(0, 6);
        if (r < 75)
            return (lim == 0) ? $urandom_range(0, 2) : $urandom_range(lim - 1, lim + 2);
        if (r < 93)
            return $urandom_range(7, 20);
        return $urandom_range(50, 70);
    endfunction

    function automatic logic [CNT_W-1:0] phase_length(int unsigned phase);
        case (phase)
            0:       return CNT_W'(1);
            1:       return CNT_W'(127);
            2:       return CNT_W'(0);
            3:       return LINE_CHARS_MAX;
            4:       return CNT_W'(17);
            5:       return CNT_W'(2);
            6:       return CNT_W'(100);
            7:       return CNT_W'(40);
            default: return CNT_W'($urandom_range(0, 127));
        endcase
    endfunction

    // Offers one byte and returns at the rising edge of its transfer.
    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = pick_gap(src_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.take_byte(it);
        sent_count++;
    endtask

    task automatic put(logic [7:0] b, logic eow);
        in_item_t it;
        it.text_byte    = b;
        it.end_of_write = eow;
        send_item(it);
    endtask

    // Ordinary characters followed by CR, LF or a CR LF pair.
    task automatic send_line(int unsigned n);
        int unsigned k;
        int unsigned r;
        for (k = 0; k < n; k++)
            put(text_char(), $urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        if (r < 35)
            put(CH_LF, $urandom_range(0, 3) != 0);
        else if (r < 60)
            put(CH_CR, 1'($urandom_range(0, 1)));
        else if (r < 90)
        begin
            put(CH_CR, 1'b0);
            put(CH_LF, $urandom_range(0, 3) != 0);
        end
        else
        begin
            put(CH_CR, 1'b1);
            put(CH_LF, 1'b1);
        end
    endtask

    // Idle the input until every awaited result is in, then let the block settle.
    task automatic wait_results_done();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(logic [CNT_W-1:0] value);
        wait_results_done();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_length(value);
        cur_length = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall_left;
        int unsigned g;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                g = pick_gap(snk_calm);
                if (g == 0)
                    out_ready = 1'b1;
                else
                begin
                    out_ready  = 1'b0;
                    stall_left = g - 1;
                end
            end
        end
    end

    // Every result transfer is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.compare_result(out_data);
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned phase;
        int unsigned next_change;
        int unsigned random_end;
        int unsigned r;
        board        = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        cur_length   = CPL_RESET;
        sent_count   = 0;
        src_calm     = 1'b0;
        snk_calm     = 1'b0;
        hold_request = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Empty lines from a lone LF, and from a CR that ends its write followed by LF.
        put(CH_LF, 1'b1);
        put(CH_CR, 1'b1);
        put(CH_LF, 1'b1);
        // Control bytes and both byte extremes are stored; the LF after CR is swallowed.
        put(8'h00, 1'b0);
        put(8'hFF, 1'b0);
        put(8'h07, 1'b0);
        put(CH_CR, 1'b0);
        put(CH_LF, 1'b1);
        // Two CRs give two empty lines; only the LF right after the second is swallowed.
        put(CH_CR, 1'b0);
        put(CH_CR, 1'b0);
        put(CH_LF, 1'b0);
        put(CH_LF, 1'b1);
        // Shortening the line while it is partly filled keeps what is already held.
        put(8'h41, 1'b0);
        put(8'h42, 1'b0);
        put(8'h43, 1'b0);
        put(8'h7F, 1'b0);
        write_length(CNT_W'(2));
        put(8'h80, 1'b0);
        put(CH_LF, 1'b1);
        // A zero line length drops every character, so the commit is empty.
        write_length(CNT_W'(0));
        put(8'h55, 1'b0);
        put(8'hAA, 1'b1);
        put(CH_CR, 1'b1);

        // Random part: phases at different line lengths, mostly well-formed lines.
        phase       = 0;
        next_change = sent_count;
        random_end  = sent_count + RANDOM_ITEMS;
        while (sent_count < random_end)
        begin
            if (sent_count >= next_change)
            begin
                write_length(phase_length(phase));
                src_calm = ($urandom_range(0, 3) == 0);
                snk_calm = ($urandom_range(0, 3) == 0);
                if (phase == 3)
                begin
                    // Long receiver hold-off while a line of 60 characters is offered at the full line length.
                    src_calm     = 1'b1;
                    hold_request = 1'b1;
                    send_line(60);
                end
                phase++;
                next_change = sent_count + PHASE_ITEMS;
            end
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                // Noise: stray line endings and raw bytes with random write boundaries.
                case ($urandom_range(0, 2))
                    0:       put(CH_CR, 1'($urandom_range(0, 1)));
                    1:       put(CH_LF, 1'($urandom_range(0, 1)));
                    default: put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                endcase
            end
            else
                send_line(pick_line_len(cur_length));
        end

        // Drain and look for stray results.
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.pending() != 0)
            board.report_leftover();
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/tcla_pkg.sv
rtl/tcla_ram.sv
rtl/text_console_line_assembler.sv
tb/text_console_line_assembler_test.sv
